>>> src/fmva_pkg.sv
// ----------------------------------------------------------------------------
// FM note voice allocator package
// Shared constants, register codes, lookup tables and types.
// ----------------------------------------------------------------------------
package fmva_pkg;

    localparam int NUM_CHANNELS    = 9;
    localparam int NUM_INSTRUMENTS = 16;
    localparam int CH_W            = $clog2(NUM_CHANNELS);
    localparam int NCH_RHYTHM      = (6 < NUM_CHANNELS) ? 6 : NUM_CHANNELS;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_NOTE_ON   = 3'd1;
    localparam logic [2:0] OP_NOTE_OFF  = 3'd2;
    localparam logic [2:0] OP_SET_DELAY = 3'd3;
    localparam logic [2:0] OP_START     = 3'd4;

    localparam logic [7:0] REG_FREQ_BASE  = 8'hA0;
    localparam logic [7:0] REG_BLOCK_BASE = 8'hB0;
    localparam logic [7:0] REG_FB_BASE    = 8'hC0;
    localparam logic [7:0] REG_RHYTHM     = 8'hBD;
    localparam logic [7:0] REG_BASS_FREQ  = 8'hA6;
    localparam logic [7:0] REG_BASS_BLOCK = 8'hB6;

    localparam logic [7:0]  KEY_OFF_MASK    = 8'hDF;
    localparam logic [7:0]  KEY_ON_BIT      = 8'h20;
    localparam logic [7:0]  OWNER_BASE      = 8'h90;
    localparam logic [7:0]  BASS_DRUM_BIT   = 8'h10;
    localparam logic [7:0]  RHYTHM_ENABLE   = 8'h20;
    localparam logic [8:0]  NOTE_BIAS       = 9'd31;
    localparam logic [13:0] COUNTDOWN_START = 14'd40;
    // 43/512 is close enough to 1/12 for every value up to 96.
    localparam logic [5:0]  RECIP_12        = 6'd43;

    typedef struct packed {
        logic [7:0] owner;
        logic [7:0] note;
        logic [7:0] blk;
    } chan_entry_t;

    typedef struct packed {
        logic [CH_W-1:0] rd_addr;
        logic            wr_en;
        logic [CH_W-1:0] wr_addr;
        chan_entry_t     wr_data;
        logic            clr_all;
    } mem_req_t;

    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] data;
        logic       wv;
        logic       due;
    } res_t;

    function automatic logic [9:0] freq_word(input logic [3:0] idx);
        logic [9:0] w;
        begin
            case (idx)
                4'd0:    w = 10'h200;
                4'd1:    w = 10'h21E;
                4'd2:    w = 10'h23F;
                4'd3:    w = 10'h261;
                4'd4:    w = 10'h285;
                4'd5:    w = 10'h2AB;
                4'd6:    w = 10'h2D4;
                4'd7:    w = 10'h300;
                4'd8:    w = 10'h32E;
                4'd9:    w = 10'h35E;
                4'd10:   w = 10'h390;
                4'd11:   w = 10'h3C7;
                default: w = 10'h200;
            endcase
            return w;
        end
    endfunction

    function automatic logic [7:0] perc_bit(input logic [2:0] rid);
        logic [7:0] b;
        begin
            case (rid)
                3'd1:    b = 8'h10;
                3'd2:    b = 8'h08;
                3'd3:    b = 8'h04;
                3'd4:    b = 8'h02;
                3'd5:    b = 8'h01;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    function automatic logic [7:0] perc_chan(input logic [2:0] rid);
        logic [7:0] c;
        begin
            case (rid)
                3'd2:    c = 8'd7;
                3'd3:    c = 8'd8;
                3'd4:    c = 8'd8;
                3'd5:    c = 8'd7;
                default: c = 8'd0;
            endcase
            return c;
        end
    endfunction

endpackage

>>> src/fm_note_voice_allocator.sv
// ----------------------------------------------------------------------------
// FM note voice allocator
// Turns timing and note events into FM synthesizer register writes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_stall) takes one event per transfer. The
// block works on one event at a time: in_stall is high from the cycle after
// a transfer until the last result of that event has been loaded into the
// output register. The output channel (out_valid/out_stall) delivers one to
// four results per event, the final one marked by last; results with
// write_valid low carry no register write.
// Ticks, delay loads, start and percussion note-on events emit their
// results with no search. Note-off and melodic note-on events first search
// the channel table one entry per cycle through the memory read port, at
// most nine entries, or six in rhythm mode. A stalled receiver holds the
// output register; the sequencer then waits and no results are lost. The
// next event is accepted while the final result still waits in the output
// register. Reset frees all channels, clears the accumulator and rhythm
// bits and sets the event countdown to forty. The APB port holds
// music_ticks at 0x0 and rhythm_mode at 0x4; the user must write it only
// while the block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module fm_note_voice_allocator
    import fmva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // event input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [3:0]  instrument,
    input  logic [7:0]  note,
    input  logic        instrument_present,
    input  logic [7:0]  rhythm_id,
    input  logic [7:0]  patch_freq_low,
    input  logic [7:0]  patch_block,
    input  logic [7:0]  patch_feedback,
    input  logic [13:0] delay,
    // register write output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  reg_address,
    output logic [7:0]  reg_data,
    output logic        write_valid,
    output logic        event_due,
    output logic        last
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [7:0]  music_ticks_reg;
    logic        rhythm_mode_reg;
    logic [7:0]  acc_reg, acc_next;
    logic [13:0] cd_reg, cd_next;
    logic [7:0]  bits_reg, bits_next;

    logic [2:0]  op_reg, op_next;
    logic [3:0]  instr_reg, instr_next;
    logic [7:0]  note_reg, note_next;
    logic        present_reg, present_next;
    logic [7:0]  rid_reg, rid_next;

    logic [CH_W-1:0] ch_reg, ch_next;
    logic [CH_W-1:0] nch_last;

    res_t        buf_reg  [4];
    res_t        buf_next [4];
    logic [2:0]  cnt_reg, cnt_next;
    logic [1:0]  idx_reg, idx_next;

    logic        out_valid_reg, out_valid_next;
    res_t        out_reg, out_next;
    logic        out_last_reg, out_last_next;

    mem_req_t    mreq;
    chan_entry_t mdata;

    logic        in_accept;
    logic        in_present;
    logic        push;
    logic        emit_last;
    logic        hit;
    logic        cfg_write;

    // Frequency path for a melodic note-on.
    logic signed [8:0] f_raw;
    logic [6:0]        f_val;
    logic [12:0]       oct_prod;
    logic [3:0]        oct;
    logic [6:0]        oct_x12;
    logic [3:0]        fidx;
    logic [9:0]        fword;
    logic [7:0]        blk_new;
    logic [7:0]        ch_byte;
    logic [8:0]        tick_sum;
    logic [13:0]       cd_dec;
    logic [7:0]        pc;

    fmva_chan_mem u_chan_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .rd_data (mdata)
    );

    // Configuration port
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = paddr[2] ? {31'd0, rhythm_mode_reg} : {24'd0, music_ticks_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            music_ticks_reg <= '0;
            rhythm_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2])
            begin
                rhythm_mode_reg <= pwdata[0];
            end
            else
            begin
                music_ticks_reg <= pwdata[7:0];
            end
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign in_present = instrument_present && ({1'b0, instrument} < 5'(NUM_INSTRUMENTS));
    assign nch_last   = rhythm_mode_reg ? CH_W'(NCH_RHYTHM - 1) : CH_W'(NUM_CHANNELS - 1);
    assign push       = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign emit_last  = ({1'b0, idx_reg} == (cnt_reg - 3'd1));
    assign ch_byte    = 8'(ch_reg);

    assign hit = (op_reg == OP_NOTE_ON) ? (mdata.owner == 8'd0)
               : ((mdata.note == note_reg) && (mdata.owner == (OWNER_BASE + {4'd0, instr_reg})));

    assign f_raw    = $signed({note_reg[7], note_reg}) - $signed(NOTE_BIAS);
    assign f_val    = f_raw[8] ? 7'd0 : f_raw[6:0];
    assign oct_prod = f_val * RECIP_12;
    assign oct      = oct_prod[12:9];
    assign oct_x12  = {oct, 3'b000} + {1'b0, oct, 2'b00};
    assign fidx     = 4'(f_val - oct_x12);
    assign fword    = freq_word(fidx);
    assign blk_new  = {2'b00, oct, 2'b00} | {6'd0, fword[9:8]} | KEY_ON_BIT;

    assign tick_sum = {1'b0, acc_reg} + {1'b0, music_ticks_reg};
    assign cd_dec   = cd_reg - 14'd1;
    assign pc       = perc_chan(rhythm_id[2:0]);

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        cd_next        = cd_reg;
        bits_next      = bits_reg;
        op_next        = op_reg;
        instr_next     = instr_reg;
        note_next      = note_reg;
        present_next   = present_reg;
        rid_next       = rid_reg;
        ch_next        = ch_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        for (int i = 0; i < 4; i++)
        begin
            buf_next[i] = buf_reg[i];
        end
        mreq = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next      = operation;
                    instr_next   = instrument;
                    note_next    = note;
                    present_next = in_present;
                    rid_next     = rhythm_id;
                    for (int i = 0; i < 4; i++)
                    begin
                        buf_next[i] = '0;
                    end
                    cnt_next   = 3'd1;
                    idx_next   = 2'd0;
                    state_next = ST_EMIT;
                    case (operation)
                        OP_TICK:
                        begin
                            acc_next = tick_sum[7:0];
                            if (tick_sum[8])
                            begin
                                cd_next         = cd_dec;
                                buf_next[0].due = (cd_dec == 14'd0);
                            end
                        end
                        OP_NOTE_ON:
                        begin
                            if (in_present && rhythm_id != 8'd0)
                            begin
                                if (rhythm_id == 8'd1)
                                begin
                                    bits_next   = bits_reg | BASS_DRUM_BIT;
                                    buf_next[0] = '{REG_BASS_FREQ, patch_freq_low, 1'b1, 1'b0};
                                    buf_next[1] = '{REG_BASS_BLOCK, patch_block & KEY_OFF_MASK,
                                                    1'b1, 1'b0};
                                    buf_next[2] = '{REG_RHYTHM, bits_next, 1'b1, 1'b0};
                                    cnt_next    = 3'd3;
                                end
                                else if (rhythm_id < 8'd6)
                                begin
                                    bits_next   = bits_reg | perc_bit(rhythm_id[2:0]);
                                    buf_next[0] = '{REG_FREQ_BASE + pc, patch_freq_low,
                                                    1'b1, 1'b0};
                                    buf_next[1] = '{REG_BLOCK_BASE + pc,
                                                    patch_block & KEY_OFF_MASK, 1'b1, 1'b0};
                                    buf_next[2] = '{REG_FB_BASE + pc, patch_feedback,
                                                    1'b1, 1'b0};
                                    buf_next[3] = '{REG_RHYTHM, bits_next, 1'b1, 1'b0};
                                    cnt_next    = 3'd4;
                                end
                            end
                            else if (in_present)
                            begin
                                mreq.rd_addr = '0;
                                ch_next      = '0;
                                state_next   = ST_SEARCH;
                            end
                        end
                        OP_NOTE_OFF:
                        begin
                            mreq.rd_addr = '0;
                            ch_next      = '0;
                            state_next   = ST_SEARCH;
                        end
                        OP_SET_DELAY:
                        begin
                            cd_next = (delay[13:1] == 13'd0) ? 14'd1 : {1'b0, delay[13:1]};
                        end
                        OP_START:
                        begin
                            mreq.clr_all = 1'b1;
                            acc_next     = '0;
                            cd_next      = COUNTDOWN_START;
                            bits_next    = rhythm_mode_reg ? RHYTHM_ENABLE : 8'd0;
                            buf_next[0]  = '{REG_RHYTHM, bits_next, 1'b1, 1'b0};
                        end
                        default:
                        begin
                            cnt_next = 3'd1;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                // mdata holds the entry of ch_reg, read in the previous cycle.
                mreq.rd_addr = ch_reg;
                if (hit)
                begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = ch_reg;
                    state_next   = ST_EMIT;
                    if (op_reg == OP_NOTE_ON)
                    begin
                        mreq.wr_data = '{OWNER_BASE + {4'd0, instr_reg}, note_reg, blk_new};
                        buf_next[0]  = '{REG_BLOCK_BASE + ch_byte, mdata.blk & KEY_OFF_MASK,
                                         1'b1, 1'b0};
                        buf_next[1]  = '{REG_FREQ_BASE + ch_byte, fword[7:0], 1'b1, 1'b0};
                        buf_next[2]  = '{REG_BLOCK_BASE + ch_byte, blk_new, 1'b1, 1'b0};
                        cnt_next     = 3'd3;
                    end
                    else
                    begin
                        mreq.wr_data = '{8'd0, mdata.note, mdata.blk};
                        buf_next[0]  = '{REG_BLOCK_BASE + ch_byte, mdata.blk & KEY_OFF_MASK,
                                         1'b1, 1'b0};
                    end
                end
                else if (ch_reg == nch_last)
                begin
                    state_next = ST_EMIT;
                    if (op_reg == OP_NOTE_OFF && present_reg && rid_reg != 8'd0
                        && rid_reg < 8'd6)
                    begin
                        bits_next   = bits_reg & ~perc_bit(rid_reg[2:0]);
                        buf_next[0] = '{REG_RHYTHM, bits_next, 1'b1, 1'b0};
                    end
                end
                else
                begin
                    ch_next      = ch_reg + CH_W'(1);
                    mreq.rd_addr = ch_next;
                end
            end
            ST_EMIT:
            begin
                if (push)
                begin
                    out_valid_next = 1'b1;
                    out_next       = buf_reg[idx_reg];
                    out_last_next  = emit_last;
                    idx_next       = idx_reg + 2'd1;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            cd_reg        <= COUNTDOWN_START;
            bits_reg      <= '0;
            out_valid_reg <= 1'b0;
            ch_reg        <= '0;
            cnt_reg       <= 3'd1;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            cd_reg        <= cd_next;
            bits_reg      <= bits_next;
            out_valid_reg <= out_valid_next;
            ch_reg        <= ch_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        instr_reg    <= instr_next;
        note_reg     <= note_next;
        present_reg  <= present_next;
        rid_reg      <= rid_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        for (int i = 0; i < 4; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
    end

    assign out_valid   = out_valid_reg;
    assign reg_address = out_reg.addr;
    assign reg_data    = out_reg.data;
    assign write_valid = out_reg.wv;
    assign event_due   = out_reg.due;
    assign last        = out_last_reg;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (cnt_reg != 3'd0 && cnt_reg <= 3'd4))
        else $error("result count out of range");

    a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (ch_reg <= nch_last))
        else $error("channel search ran past the active channels");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != ST_IDLE))
        else $error("accepted event did not start processing");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (push && emit_last) |=> (state_reg == ST_IDLE && out_valid_reg && out_last_reg))
        else $error("final result did not end the event");
`endif

endmodule

>>> src/fmva_chan_mem.sv
// ----------------------------------------------------------------------------
// FM voice allocator channel memory
// Synchronous channel table with a registered read port and per-entry valid
// bits; an entry that is not valid reads as zero.
// ----------------------------------------------------------------------------
module fmva_chan_mem
    import fmva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mem_req_t    req,
    output chan_entry_t rd_data
);

    chan_entry_t                    mem [NUM_CHANNELS];
    logic        [NUM_CHANNELS-1:0] valid_reg;
    chan_entry_t                    rd_data_reg;
    logic                           rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[req.rd_addr];
            if (req.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule
